// File: hdl/ic_pkg.sv
// Shared types and constants for the inversion counter.
`timescale 1ns / 1ps

package ic_pkg;

  // Default capacity, in elements, of one array
  localparam int MAX_ITEMS_DEF = 256;

  // Element and result widths
  localparam int VALUE_W = 32;
  localparam int TOTAL_W = 15;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Sign bias: an unsigned compare of biased keys matches signed order
  localparam logic [VALUE_W-1:0] SIGN_BIAS = {1'b1, {(VALUE_W-1){1'b0}}};

  // Request token that travels down the row of cells
  typedef struct packed {
    logic               valid;
    logic               last;    // closes the array; clears cells it passes
    logic               drop;    // arrived beyond capacity
    logic               placed;  // key already written into a cell
    logic [VALUE_W-1:0] key;     // sign-biased element value
  } ic_tok_t;

endpackage

// File: hdl/ic_cell.sv
// One compare-and-store cell of the inversion counter row.
`timescale 1ns / 1ps

module ic_cell
  import ic_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  ic_tok_t                      tok_i,
  input  logic [$clog2(MAX_ITEMS)-1:0] cnt_i,
  output ic_tok_t                      tok_o,
  output logic [$clog2(MAX_ITEMS)-1:0] cnt_o
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  logic               occ_r, occ_nxt;
  logic [VALUE_W-1:0] val_r;
  ic_tok_t            tok_r, tok_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               hit;
  logic               store;

  // Compare against the held element, claim the cell if free
  always_comb begin
    hit   = tok_i.valid && occ_r && !tok_i.drop && (val_r > tok_i.key);
    store = tok_i.valid && !occ_r && !tok_i.placed && !tok_i.drop && !tok_i.last;

    occ_nxt = occ_r;
    if (tok_i.valid && tok_i.last) begin
      occ_nxt = 1'b0;
    end else if (store) begin
      occ_nxt = 1'b1;
    end

    tok_nxt        = tok_i;
    tok_nxt.placed = tok_i.placed || store;
    cnt_nxt        = cnt_i + CNT_W'(hit);
  end

  // Cell state and forwarded request; only the control bits are reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= 1'b0;
      tok_r.valid <= 1'b0;
    end else if (adv) begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
      cnt_r <= cnt_nxt;
      if (store) begin
        val_r <= tok_i.key;
      end
    end
  end

  assign tok_o = tok_r;
  assign cnt_o = cnt_r;

endmodule

// File: hdl/ic_tail.sv
// End of the cell row: running total, overflow flag and result register.
`timescale 1ns / 1ps

module ic_tail
  import ic_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ic_tok_t                      tok_i,
  input  logic [$clog2(MAX_ITEMS)-1:0] cnt_i,
  output logic                         adv,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [TOTAL_W-1:0]           out_inversions,
  output logic                         out_too_many
);

  localparam int SUM_W = TOTAL_W + 1;

  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               ovf_r;
  logic               out_valid_r;
  logic [TOTAL_W-1:0] out_inv_r;
  logic               out_tm_r;
  logic [SUM_W-1:0]   sum;
  logic               take;

  // The row stalls only when a closing request meets a result not yet taken
  assign adv  = !(tok_i.valid && tok_i.last && out_valid_r && !out_ready);
  assign take = tok_i.valid && adv;

  // Saturating add of the count carried out of the row
  always_comb begin
    sum = {1'b0, total_r} + SUM_W'(cnt_i);
    if (sum > SUM_W'(TOTAL_MAX)) begin
      total_nxt = TOTAL_MAX;
    end else begin
      total_nxt = sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (take) begin
        if (tok_i.last) begin
          total_r     <= '0;
          ovf_r       <= 1'b0;
          out_valid_r <= 1'b1;
          out_inv_r   <= total_nxt;
          out_tm_r    <= ovf_r || tok_i.drop;
        end else begin
          total_r <= total_nxt;
          ovf_r   <= ovf_r || tok_i.drop;
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inversions = out_inv_r;
  assign out_too_many   = out_tm_r;

endmodule

// File: hdl/inversion_counter_core.sv
// Top level of the inversion counter: entry logic and the row of cells.
`timescale 1ns / 1ps

// Counts inversions (earlier element strictly greater than a later one) of a
// signed 32-bit array streamed in one element per request, in_last on the
// final one. Each request travels a row of MAX_ITEMS cells, one cell per
// cycle unless the row stalls; every cell holds at most one stored element,
// compares it with the passing request and the first free cell keeps the
// new element. A new element is taken every cycle unless in_ready is low.
// The result for an array appears on out_valid after its last element is
// accepted: the accepting edge loads the first cell, the request then
// crosses the other MAX_ITEMS - 1 cells and the result register. in_ready
// drops only while a result is waiting on the output and the next closing
// request has reached the end of the row. Elements past MAX_ITEMS are
// dropped and reported through out_too_many; the total saturates at 32767.
module inversion_counter_core
  import ic_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [TOTAL_W-1:0]        out_inversions,
  output logic                      out_too_many
);

  localparam int CNT_W  = $clog2(MAX_ITEMS);
  localparam int FILL_W = $clog2(MAX_ITEMS + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MAX_ITEMS);

  logic              adv;
  logic              accept;
  logic              full;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  ic_tok_t           tok_w [0:MAX_ITEMS];
  logic [CNT_W-1:0]  cnt_w [0:MAX_ITEMS];

  assign in_ready = adv;
  assign accept   = in_valid && adv;
  assign full     = (fill_r == FILL_FULL);

  // Elements entered for the current array
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_last) begin
        fill_nxt = '0;
      end else if (!full) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Request entering the row
  always_comb begin
    tok_w[0].valid  = in_valid;
    tok_w[0].last   = in_last;
    tok_w[0].drop   = full;
    tok_w[0].placed = 1'b0;
    tok_w[0].key    = in_value ^ SIGN_BIAS;
    cnt_w[0]        = '0;
  end

  // Row of compare-and-store cells
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    ic_cell #(
      .MAX_ITEMS (MAX_ITEMS)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (tok_w[g]),
      .cnt_i (cnt_w[g]),
      .tok_o (tok_w[g+1]),
      .cnt_o (cnt_w[g+1])
    );
  end

  ic_tail #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_tail (
    .clk            (clk),
    .rst_n          (rst_n),
    .tok_i          (tok_w[MAX_ITEMS]),
    .cnt_i          (cnt_w[MAX_ITEMS]),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inversions (out_inversions),
    .out_too_many   (out_too_many)
  );

  // Checks
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("fill count beyond capacity");

  a_fill_clear : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (fill_r == '0))
    else $error("fill count not cleared after closing request");

  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready && tok_w[MAX_ITEMS].valid
                   && tok_w[MAX_ITEMS].last))
    else $error("row stalled without a pending result");

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fill_r))
    else $error("fill count moved during stall");

endmodule
